>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file (pdgi_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define PDGI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is low.
`define PDGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pdgi_pkg.sv
`timescale 1ns / 1ps

package pdgi_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;

	// pipeline shape: squares, sum, 32 root steps, two coefficient stages
	localparam int unsigned ROOT_STEPS   = 32;
	localparam int unsigned MAG_STAGES   = ROOT_STEPS + 4;
	localparam int unsigned INTEG_STAGES = 8;
	localparam int unsigned PIPE_DEPTH   = MAG_STAGES + INTEG_STAGES;

	localparam int unsigned ADDR_W = 5;
	localparam logic signed [23:0] GRAV_Z_RST = -24'sd642253;
	localparam logic [16:0] TIME_STEP_RST = 17'd1092;

	typedef enum logic [2:0] {
		REG_GRAV_X    = 3'd0,
		REG_GRAV_Y    = 3'd1,
		REG_GRAV_Z    = 3'd2,
		REG_DRAG_COEF = 3'd3,
		REG_DRAG_EN   = 3'd4,
		REG_TIME_STEP = 3'd5
	} reg_idx_t;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		logic signed [23:0] grav_x;
		logic signed [23:0] grav_y;
		logic signed [23:0] grav_z;
		logic [22:0]        drag_coef;
		logic               drag_en;
		logic [16:0]        time_step;
	} cfg_t;

	typedef struct packed {
		q_t [2:0]    pos;
		q_t [2:0]    vel;
		q_t [2:0]    frc;
		logic [30:0] inv_mass;
		logic [16:0] damp;
	} particle_t;

	typedef struct packed {
		particle_t   pkt;
		logic [30:0] coef;
	} mag_t;

	typedef struct packed {
		q_t [2:0] pos;
		q_t [2:0] vel;
	} result_t;

	// saturate to the signed 32-bit range
	function automatic q_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// round to nearest, ties up: floor((p + half) / 2^f)
	function automatic logic signed [65:0] rnd(input logic signed [65:0] p,
			input int unsigned f);
		logic signed [65:0] half;
		half = $signed(66'd1 << (f - 1));
		return (p + half) >>> f;
	endfunction

	// unsigned round, clamp to 2^31-1
	function automatic logic [30:0] urnd_sat(input logic [63:0] p, input int unsigned f);
		logic [64:0] q;
		q = ({1'b0, p} + (65'd1 << (f - 1))) >> f;
		return (q > 65'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
	endfunction

endpackage

>>> rtl/core/pdgi_if.sv
`timescale 1ns / 1ps

interface pdgi_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [31:0] vel_z;
	logic [31:0] force_x;
	logic [31:0] force_y;
	logic [31:0] force_z;
	logic [30:0] inv_mass;
	logic [16:0] damping_factor;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		force_x, force_y, force_z, inv_mass, damping_factor, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		force_x, force_y, force_z, inv_mass, damping_factor, output ready);
endinterface

interface pdgi_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_pos_x;
	logic [31:0] new_pos_y;
	logic [31:0] new_pos_z;
	logic [31:0] new_vel_x;
	logic [31:0] new_vel_y;
	logic [31:0] new_vel_z;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
		new_vel_x, new_vel_y, new_vel_z, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_pos_z,
		new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

>>> rtl/core/pdgi_regs.sv
`timescale 1ns / 1ps

module pdgi_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pdgi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output pdgi_pkg::cfg_t             cfg
);

	pdgi_pkg::cfg_t   cfg_q;
	pdgi_pkg::reg_idx_t idx;

	assign idx    = pdgi_pkg::reg_idx_t'(paddr[pdgi_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grav_x    <= '0;
			cfg_q.grav_y    <= '0;
			cfg_q.grav_z    <= pdgi_pkg::GRAV_Z_RST;
			cfg_q.drag_coef <= '0;
			cfg_q.drag_en   <= 1'b0;
			cfg_q.time_step <= pdgi_pkg::TIME_STEP_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				pdgi_pkg::REG_GRAV_X:    cfg_q.grav_x    <= pwdata[23:0];
				pdgi_pkg::REG_GRAV_Y:    cfg_q.grav_y    <= pwdata[23:0];
				pdgi_pkg::REG_GRAV_Z:    cfg_q.grav_z    <= pwdata[23:0];
				pdgi_pkg::REG_DRAG_COEF: cfg_q.drag_coef <= pwdata[22:0];
				pdgi_pkg::REG_DRAG_EN:   cfg_q.drag_en   <= pwdata[0];
				pdgi_pkg::REG_TIME_STEP: cfg_q.time_step <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			pdgi_pkg::REG_GRAV_X:    prdata = {8'd0, cfg_q.grav_x};
			pdgi_pkg::REG_GRAV_Y:    prdata = {8'd0, cfg_q.grav_y};
			pdgi_pkg::REG_GRAV_Z:    prdata = {8'd0, cfg_q.grav_z};
			pdgi_pkg::REG_DRAG_COEF: prdata = {9'd0, cfg_q.drag_coef};
			pdgi_pkg::REG_DRAG_EN:   prdata = {31'd0, cfg_q.drag_en};
			pdgi_pkg::REG_TIME_STEP: prdata = {15'd0, cfg_q.time_step};
			default:                 prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/pdgi_mag.sv
`timescale 1ns / 1ps

// Speed magnitude and drag coefficient c = d + d^2*|v|.
module pdgi_mag #(
	parameter int unsigned FRAC_BITS = pdgi_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdgi_pkg::cfg_t        cfg,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  pdgi_pkg::particle_t   up_data,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output pdgi_pkg::mag_t        dn_data
);

	localparam int unsigned N  = pdgi_pkg::MAG_STAGES;
	localparam int unsigned RS = pdgi_pkg::ROOT_STEPS;

	logic [N-1:0]        vld_s;
	logic [N-1:0]        en;
	pdgi_pkg::particle_t pay_s [N];

	logic [63:0] sq_s1 [3];
	logic [63:0] sum_s2;
	logic [63:0] rem_s [RS];
	logic [63:0] root_s [RS];
	logic [62:0] tp_s35;
	logic [30:0] coef_s36;
	logic [30:0] dsq_q;
	logic [31:0] absv [3];

	// stage advances when empty or when the one after it moves
	always_comb begin
		en[N-1] = !vld_s[N-1] || dn_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign up_ready = en[0];
	assign dn_valid = vld_s[N-1];
	assign dn_data  = '{pkt: pay_s[N-1], coef: coef_s36};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= up_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// particle rides along
	always_ff @(posedge clk) begin
		if (en[0]) pay_s[0] <= up_data;
		for (int k = 1; k < N; k++) begin
			if (en[k]) pay_s[k] <= pay_s[k-1];
		end
	end

	// d^2 depends on configuration only
	always_ff @(posedge clk) begin
		dsq_q <= pdgi_pkg::urnd_sat(64'(46'(cfg.drag_coef) * 46'(cfg.drag_coef)), FRAC_BITS);
	end

	// squares of the velocity components
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			absv[i] = up_data.vel[i][31] ? 32'(-up_data.vel[i]) : up_data.vel[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 64'(absv[i]) * 64'(absv[i]);
			end
		end
		if (en[1]) sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
	end

	// integer square root, one result bit per stage
	for (genvar j = 0; j < RS; j++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (2 * (RS - 1 - j));
		logic [63:0] x_in;
		logic [63:0] r_in;
		logic [63:0] trial;

		if (j == 0) begin : g_first
			assign x_in = sum_s2;
			assign r_in = '0;
		end else begin : g_next
			assign x_in = rem_s[j-1];
			assign r_in = root_s[j-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				if (x_in >= trial) begin
					rem_s[j]  <= x_in - trial;
					root_s[j] <= (r_in >> 1) + BIT;
				end else begin
					rem_s[j]  <= x_in;
					root_s[j] <= r_in >> 1;
				end
			end
		end
	end

	// d^2*|v|, then c
	always_ff @(posedge clk) begin
		if (en[N-2]) tp_s35 <= 63'(dsq_q) * 63'(root_s[RS-1][31:0]);
		if (en[N-1]) begin
			coef_s36 <= ((32'(cfg.drag_coef) +
				32'(pdgi_pkg::urnd_sat(64'(tp_s35), FRAC_BITS))) > 32'h7FFF_FFFF) ?
				31'h7FFF_FFFF :
				31'(32'(cfg.drag_coef) + 32'(pdgi_pkg::urnd_sat(64'(tp_s35), FRAC_BITS)));
		end
	end

endmodule

>>> rtl/core/pdgi_integ.sv
`timescale 1ns / 1ps

// Drag force, acceleration and Euler update for all three axes.
module pdgi_integ #(
	parameter int unsigned FRAC_BITS = pdgi_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pdgi_pkg::cfg_t    cfg,
	input  logic              up_valid,
	output logic              up_ready,
	input  pdgi_pkg::mag_t    up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output pdgi_pkg::result_t dn_data
);

	localparam int unsigned N = pdgi_pkg::INTEG_STAGES;

	logic [N-1:0] vld_s;
	logic [N-1:0] en;

	logic signed [63:0] dragp_s1 [3];
	logic signed [49:0] vdt_s1 [3];
	pdgi_pkg::q_t       pos_s1 [3];
	pdgi_pkg::q_t       frc_s1 [3];
	pdgi_pkg::q_t       v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3];
	logic [30:0]        inv_s1, inv_s2;
	logic [16:0]        damp_s1, damp_s2, damp_s3, damp_s4, damp_s5, damp_s6;
	pdgi_pkg::q_t       ftot_s2 [3];
	pdgi_pkg::q_t       np_s2 [3], np_s3 [3], np_s4 [3], np_s5 [3];
	pdgi_pkg::q_t       np_s6 [3], np_s7 [3], np_s8 [3];
	logic signed [63:0] fm_s3 [3];
	pdgi_pkg::q_t       acc_s4 [3];
	logic signed [49:0] adt_s5 [3];
	pdgi_pkg::q_t       vt_s6 [3];
	logic signed [49:0] vd_s7 [3];
	pdgi_pkg::q_t       nv_s8 [3];

	logic signed [23:0] grav [3];
	logic signed [17:0] dt_s;
	logic signed [31:0] coef_s;

	assign grav[0] = cfg.grav_x;
	assign grav[1] = cfg.grav_y;
	assign grav[2] = cfg.grav_z;
	assign dt_s    = $signed({1'b0, cfg.time_step});
	assign coef_s  = $signed({1'b0, up_data.coef});

	always_comb begin
		en[N-1] = !vld_s[N-1] || dn_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign up_ready = en[0];
	assign dn_valid = vld_s[N-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dn_data.pos[i] = np_s8[i];
			dn_data.vel[i] = nv_s8[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= up_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		// s1: c*v and v*dt products
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				dragp_s1[i] <= cfg.drag_en ? coef_s * $signed(up_data.pkt.vel[i]) : 64'sd0;
				vdt_s1[i]   <= $signed(up_data.pkt.vel[i]) * dt_s;
				pos_s1[i]   <= up_data.pkt.pos[i];
				frc_s1[i]   <= up_data.pkt.frc[i];
				v_s1[i]     <= up_data.pkt.vel[i];
			end
			inv_s1  <= up_data.pkt.inv_mass;
			damp_s1 <= up_data.pkt.damp;
		end
		// s2: total force and new position
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				ftot_s2[i] <= pdgi_pkg::sat32(66'(frc_s1[i]) + 66'(pdgi_pkg::sat32(
					pdgi_pkg::rnd(-66'(dragp_s1[i]), FRAC_BITS))));
				np_s2[i] <= pdgi_pkg::sat32(66'(pos_s1[i]) +
					pdgi_pkg::rnd(66'(vdt_s1[i]), FRAC_BITS));
				v_s2[i] <= v_s1[i];
			end
			inv_s2  <= inv_s1;
			damp_s2 <= damp_s1;
		end
		// s3: force times inverse mass
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				fm_s3[i] <= ftot_s2[i] * $signed({1'b0, inv_s2});
				np_s3[i] <= np_s2[i];
				v_s3[i]  <= v_s2[i];
			end
			damp_s3 <= damp_s2;
		end
		// s4: acceleration with gravity
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= pdgi_pkg::sat32(pdgi_pkg::rnd(66'(fm_s3[i]), FRAC_BITS) +
					66'(grav[i]));
				np_s4[i] <= np_s3[i];
				v_s4[i]  <= v_s3[i];
			end
			damp_s4 <= damp_s3;
		end
		// s5: a*dt
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				adt_s5[i] <= acc_s4[i] * dt_s;
				np_s5[i]  <= np_s4[i];
				v_s5[i]   <= v_s4[i];
			end
			damp_s5 <= damp_s4;
		end
		// s6: undamped velocity
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				vt_s6[i] <= pdgi_pkg::sat32(66'(v_s5[i]) +
					pdgi_pkg::rnd(66'(adt_s5[i]), FRAC_BITS));
				np_s6[i] <= np_s5[i];
			end
			damp_s6 <= damp_s5;
		end
		// s7: damping product
		if (en[6]) begin
			for (int i = 0; i < 3; i++) begin
				vd_s7[i] <= vt_s6[i] * $signed({1'b0, damp_s6});
				np_s7[i] <= np_s6[i];
			end
		end
		// s8: output register
		if (en[7]) begin
			for (int i = 0; i < 3; i++) begin
				nv_s8[i] <= pdgi_pkg::sat32(pdgi_pkg::rnd(66'(vd_s7[i]), FRAC_BITS));
				np_s8[i] <= np_s7[i];
			end
		end
	end

endmodule

>>> rtl/core/particle_drag_gravity_integrator_unit.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake       Payload
// particle   in   valid/ready     pos, vel, force xyz, inv_mass, damping_factor
// result     out  valid/ready     new_pos, new_vel xyz
// apb        in   psel/penable    gravity, drag, time step registers
//
// One particle per cycle sustained while the result side is ready; each passes the
// magnitude/root pipeline, then the integration pipeline.
// Every stage holds its request while the next is full; bubbles are
// squeezed out, so a stalled result never blocks new requests until
// all 44 stages are occupied.
// Reset clears the valid bits and loads the register defaults.
module particle_drag_gravity_integrator_unit #(
	parameter int unsigned FRAC_BITS = pdgi_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pdgi_in_if.sink                     particle,
	pdgi_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdgi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	pdgi_pkg::cfg_t      cfg;
	pdgi_pkg::particle_t in_pkt;
	pdgi_pkg::mag_t      mag_data;
	pdgi_pkg::result_t   res_data;
	logic                mag_valid;
	logic                mag_ready;

	assign in_pkt.pos[0]   = particle.pos_x;
	assign in_pkt.pos[1]   = particle.pos_y;
	assign in_pkt.pos[2]   = particle.pos_z;
	assign in_pkt.vel[0]   = particle.vel_x;
	assign in_pkt.vel[1]   = particle.vel_y;
	assign in_pkt.vel[2]   = particle.vel_z;
	assign in_pkt.frc[0]   = particle.force_x;
	assign in_pkt.frc[1]   = particle.force_y;
	assign in_pkt.frc[2]   = particle.force_z;
	assign in_pkt.inv_mass = particle.inv_mass;
	assign in_pkt.damp     = particle.damping_factor;

	pdgi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdgi_mag #(.FRAC_BITS(FRAC_BITS)) u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (particle.valid),
		.up_ready (particle.ready),
		.up_data  (in_pkt),
		.dn_valid (mag_valid),
		.dn_ready (mag_ready),
		.dn_data  (mag_data)
	);

	pdgi_integ #(.FRAC_BITS(FRAC_BITS)) u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (mag_valid),
		.up_ready (mag_ready),
		.up_data  (mag_data),
		.dn_valid (result.valid),
		.dn_ready (result.ready),
		.dn_data  (res_data)
	);

	assign result.new_pos_x = res_data.pos[0];
	assign result.new_pos_y = res_data.pos[1];
	assign result.new_pos_z = res_data.pos[2];
	assign result.new_vel_x = res_data.vel[0];
	assign result.new_vel_y = res_data.vel[1];
	assign result.new_vel_z = res_data.vel[2];

endmodule

>>> rtl/core/pdgi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdgi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] new_pos_x
);

	localparam int unsigned CNT_W = $clog2(pdgi_pkg::PIPE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(pdgi_pkg::PIPE_DEPTH);

	logic [CNT_W-1:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	`PDGI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`PDGI_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(new_pos_x), "result changed while stalled")
	`PDGI_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, cnt_q != '0, "result with nothing in flight")
	`PDGI_ASSERT_NOW(a_ready_room, clk, arst_n, cnt_q < DEPTH, in_ready, "request refused with free stage")
	`PDGI_ASSERT_NOW(a_depth, clk, arst_n, 1'b1, cnt_q <= DEPTH, "more in flight than stages")

endmodule

bind particle_drag_gravity_integrator_unit pdgi_checker u_pdgi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (particle.valid),
	.in_ready  (particle.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.new_pos_x (result.new_pos_x)
);

>>> test/pdgi_tb_if.sv
`timescale 1ns / 1ps

// Channel interfaces come from the RTL (pdgi_if.sv); this file only holds
// the small bundles used by the testbench to pass a particle and its update around.
package pdgi_tb_pkg;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
		logic signed [31:0] frc [3];
		logic [30:0] inv_mass;
		logic [16:0] damp;
	} part_s;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
	} upd_s;
endpackage

>>> test/particle_drag_gravity_integrator_unit_test.sv
`timescale 1ns / 1ps

module particle_drag_gravity_integrator_unit_test;

	localparam int F = 16;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam longint CYCLE_LIMIT = 800000;

	// register shadow used by the predictor
	logic signed [23:0] grav [3];
	logic [22:0] drag_d;
	logic drag_on;
	logic [16:0] dt;

	function automatic longint clamp32(longint v);
		if (v > QMAX) return QMAX;
		if (v < QMIN) return QMIN;
		return v;
	endfunction

	// round half up: arithmetic shift is floor
	function automatic longint round_q(longint p);
		return (p + (64'sd1 <<< (F - 1))) >>> F;
	endfunction

	function automatic longint uround_clamp(longint unsigned p);
		longint unsigned q;
		q = (p + (64'd1 << (F - 1))) >> F;
		return (q > QMAX) ? QMAX : q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// one Euler step with drag, gravity and damping
	function automatic pdgi_tb_pkg::upd_s integrate(pdgi_tb_pkg::part_s p);
		pdgi_tb_pkg::upd_s u;
		longint unsigned sum, mag, d2, t, c, av;
		longint drag, ftot, acc, vt;
		c = 0;
		if (drag_on) begin
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				av = (p.vel[i] < 0) ? -longint'(p.vel[i]) : longint'(p.vel[i]);
				sum += av * av;
			end
			mag = int_sqrt(sum);
			d2 = uround_clamp(longint'(drag_d) * longint'(drag_d));
			t = uround_clamp(d2 * mag);
			c = drag_d + t;
			if (c > QMAX) c = QMAX;
		end
		for (int i = 0; i < 3; i++) begin
			drag = drag_on ? clamp32(round_q(-(longint'(c) * longint'(p.vel[i])))) : 0;
			ftot = clamp32(longint'(p.frc[i]) + drag);
			acc = clamp32(round_q(ftot * longint'({1'b0, p.inv_mass})) + longint'(grav[i]));
			u.pos[i] = 32'(clamp32(longint'(p.pos[i]) +
				round_q(longint'(p.vel[i]) * longint'(dt))));
			vt = clamp32(longint'(p.vel[i]) + round_q(acc * longint'(dt)));
			u.vel[i] = 32'(clamp32(round_q(vt * longint'(p.damp))));
		end
		return u;
	endfunction

	// expected updates in request order
	class update_board;
		pdgi_tb_pkg::upd_s pending [$];
		int errors;

		function void note_particle(pdgi_tb_pkg::upd_s u);
			pending.push_back(u);
		endfunction

		function void check_update(pdgi_tb_pkg::upd_s got);
			pdgi_tb_pkg::upd_s e;
			if (pending.size() == 0) begin
				$error("result with no particle pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (got.pos[i] !== e.pos[i]) begin
					$error("new_pos[%0d] expected %0d got %0d", i, e.pos[i], got.pos[i]);
					errors++;
				end
				if (got.vel[i] !== e.vel[i]) begin
					$error("new_vel[%0d] expected %0d got %0d", i, e.vel[i], got.vel[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [pdgi_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	longint cycles = 0;
	int stall_cnt = 0;
	update_board board = new();

	pdgi_in_if particle ();
	pdgi_out_if result ();

	initial begin
		particle.valid = 0;
		particle.pos_x = 0; particle.pos_y = 0; particle.pos_z = 0;
		particle.vel_x = 0; particle.vel_y = 0; particle.vel_z = 0;
		particle.force_x = 0; particle.force_y = 0; particle.force_z = 0;
		particle.inv_mass = 0; particle.damping_factor = 0;
		result.ready = 0;
	end

	particle_drag_gravity_integrator_unit u_top (
		.clk(clk), .arst_n(arst_n), .particle(particle.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, a few long, check accepted updates
	always @(posedge clk) begin
		pdgi_tb_pkg::upd_s got;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				got.pos[0] = result.new_pos_x; got.pos[1] = result.new_pos_y;
				got.pos[2] = result.new_pos_z;
				got.vel[0] = result.new_vel_x; got.vel[1] = result.new_vel_y;
				got.vel[2] = result.new_vel_z;
				board.check_update(got);
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				result.ready <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				stall_cnt = $urandom_range(20, 80);
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	// predictor mirror and APB write
	task automatic write_reg(pdgi_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= pdgi_pkg::ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			pdgi_pkg::REG_GRAV_X: grav[0] = val[23:0];
			pdgi_pkg::REG_GRAV_Y: grav[1] = val[23:0];
			pdgi_pkg::REG_GRAV_Z: grav[2] = val[23:0];
			pdgi_pkg::REG_DRAG_COEF: drag_d = val[22:0];
			pdgi_pkg::REG_DRAG_EN: drag_on = val[0];
			default: dt = val[16:0];
		endcase
	endtask

	// after a random idle gap, present one particle, hold until accepted
	task automatic send_particle(pdgi_tb_pkg::part_s p);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			particle.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		particle.valid <= 1;
		particle.pos_x <= p.pos[0]; particle.pos_y <= p.pos[1]; particle.pos_z <= p.pos[2];
		particle.vel_x <= p.vel[0]; particle.vel_y <= p.vel[1]; particle.vel_z <= p.vel[2];
		particle.force_x <= p.frc[0]; particle.force_y <= p.frc[1];
		particle.force_z <= p.frc[2];
		particle.inv_mass <= p.inv_mass; particle.damping_factor <= p.damp;
		do @(posedge clk); while (!particle.ready);
		board.note_particle(integrate(p));
	endtask

	function automatic logic [31:0] rand_q(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 400000)) - 200000);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
		endcase
	endfunction

	function automatic pdgi_tb_pkg::part_s rand_particle();
		pdgi_tb_pkg::part_s p;
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = rand_q($urandom_range(0, 3));
			p.vel[i] = rand_q($urandom_range(0, 3));
			p.frc[i] = rand_q($urandom_range(0, 3));
		end
		case ($urandom_range(0, 3))
			0: p.inv_mass = 31'($urandom());
			1: p.inv_mass = 31'd0;
			default: p.inv_mass = 31'($urandom_range(0, 262144));
		endcase
		case ($urandom_range(0, 3))
			0: p.damp = 17'($urandom());
			1: p.damp = 17'd65536;
			default: p.damp = 17'($urandom_range(50000, 65536));
		endcase
		return p;
	endfunction

	// idle the input, wait for every pending result
	task automatic drain();
		particle.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		pdgi_tb_pkg::part_s p;
		grav[0] = 0; grav[1] = 0; grav[2] = pdgi_pkg::GRAV_Z_RST;
		drag_d = 0; drag_on = 0; dt = pdgi_pkg::TIME_STEP_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero mass, zero step, damping above one
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 3; i++) begin
				p.pos[i] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
				p.vel[i] = k[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
				p.frc[i] = k[2] ? 32'h7FFF_FFFF : 32'h8000_0000;
			end
			p.inv_mass = (k < 4) ? 31'h7FFF_FFFF : ((k < 8) ? 31'd0 : 31'd65536);
			p.damp = (k % 3 == 0) ? 17'h1FFFF : ((k % 3 == 1) ? 17'd0 : 17'd65536);
			send_particle(p);
		end
		drain();
		write_reg(pdgi_pkg::REG_TIME_STEP, 32'd0);
		write_reg(pdgi_pkg::REG_DRAG_EN, 32'd1);
		write_reg(pdgi_pkg::REG_DRAG_COEF, 32'h7F_FFFF);
		write_reg(pdgi_pkg::REG_GRAV_X, 32'h7F_FFFF);
		write_reg(pdgi_pkg::REG_GRAV_Y, 32'hFF80_0000);
		write_reg(pdgi_pkg::REG_GRAV_Z, 32'd0);
		for (int k = 0; k < 8; k++) begin
			p = rand_particle();
			if (k[0]) p.vel[0] = 32'h8000_0000;
			send_particle(p);
		end
		drain();
		write_reg(pdgi_pkg::REG_TIME_STEP, 32'h1FFFF);
		for (int k = 0; k < 4; k++) send_particle(rand_particle());

		// random phases with varied register settings
		for (int ph = 0; ph < 13; ph++) begin
			drain();
			write_reg(pdgi_pkg::REG_GRAV_X, $urandom());
			write_reg(pdgi_pkg::REG_GRAV_Y, $urandom_range(0, 1) ? $urandom() : 32'd0);
			write_reg(pdgi_pkg::REG_GRAV_Z, (ph == 0) ? 32'hFFF6_33B3 : $urandom());
			write_reg(pdgi_pkg::REG_DRAG_COEF, $urandom_range(0, 2) == 0 ? $urandom() :
				$urandom_range(0, 40000));
			write_reg(pdgi_pkg::REG_DRAG_EN, $urandom_range(0, 1));
			case (ph % 4)
				0: write_reg(pdgi_pkg::REG_TIME_STEP, 32'd1);
				1: write_reg(pdgi_pkg::REG_TIME_STEP, 32'd65536);
				default: write_reg(pdgi_pkg::REG_TIME_STEP, $urandom());
			endcase
			for (int k = 0; k < 148; k++) send_particle(rand_particle());
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pdgi_pkg.sv
rtl/core/pdgi_if.sv
rtl/core/pdgi_regs.sv
rtl/core/pdgi_mag.sv
rtl/core/pdgi_integ.sv
rtl/core/particle_drag_gravity_integrator_unit.sv
rtl/core/pdgi_checker.sv
test/pdgi_tb_if.sv
test/particle_drag_gravity_integrator_unit_test.sv
